### hw/rtl/blg_pkg.sv
// Shared types, constants and lookup functions for the battery level LED gauge.
`timescale 1ns / 1ps

package blg_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 5;
   localparam int MV_W = 13;
   localparam int CODE_W = 7;
   localparam int LED_W = 4;
   localparam int BAND_W = 3;
   localparam int NUM_THR = 5;

   localparam logic [MV_W-1:0] FLOOR_RESET = 13'd3000;
   localparam logic [MV_W-1:0] MV_OFFSET = 13'd2304;
   localparam logic [LED_W-1:0] LED_ALL = 4'hF;
   localparam logic [BAND_W-1:0] BAND_FULL = 3'd5;

   typedef enum logic [1:0] {
      MODE_OFF       = 2'd0,
      MODE_SHOW      = 2'd1,
      MODE_CHARGE    = 2'd2,
      MODE_DISCHARGE = 2'd3
   } mode_type;

   localparam logic [MV_W-1:0] CHG_THR [NUM_THR] = '{13'd3650, 13'd3700, 13'd3800,
                                                     13'd3950, 13'd4110};
   localparam logic [MV_W-1:0] DIS_THR [NUM_THR] = '{13'd3530, 13'd3660, 13'd3740,
                                                     13'd3900, 13'd4110};
   localparam logic [LED_W-1:0] PAT_ON [NUM_THR] = '{4'h0, 4'h0, 4'h4, 4'h6, 4'h7};
   localparam logic [LED_W-1:0] PAT_OFF [NUM_THR] = '{4'h0, 4'h4, 4'h6, 4'h7, 4'hF};

   typedef struct packed {
      logic capture;
      logic clear_win;
      logic scan_step;
      logic insert;
      logic div_load;
      logic div_step;
      logic result_load;
   } blg_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     scan_last;
      logic     div_last;
   } blg_sts_type;

   // Returns the first band whose threshold is not below the value, or the full band.
   function automatic logic [BAND_W-1:0] band_of(input logic [MV_W-1:0] mv,
                                                 input logic discharge);
      logic [BAND_W-1:0] band;
      logic [MV_W-1:0]   thr;
      band = BAND_FULL;
      for (int k = NUM_THR - 1; k >= 0; k--) begin
         thr = discharge ? DIS_THR[k] : CHG_THR[k];
         if (mv <= thr) begin
            band = BAND_W'(k);
         end
      end
      return band;
   endfunction

   function automatic logic [LED_W-1:0] pattern_of(input logic [BAND_W-1:0] band,
                                                   input logic phase_on);
      logic [LED_W-1:0] pat;
      pat = LED_ALL;
      for (int k = 0; k < NUM_THR; k++) begin
         if (band == BAND_W'(k)) begin
            pat = phase_on ? PAT_ON[k] : PAT_OFF[k];
         end
      end
      return pat;
   endfunction

endpackage

### hw/rtl/blg_datapath.sv
// Datapath of the gauge: sample window, scan accumulator, serial divider and result register.
`timescale 1ns / 1ps

module blg_datapath #(
   parameter int WINDOW_DEPTH = blg_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  blg_pkg::blg_cmd_type          cmd,
   output blg_pkg::blg_sts_type          sts,
   input  logic [1:0]                    req_display_mode,
   input  logic [blg_pkg::CODE_W-1:0]    req_battery_code,
   input  logic                          req_charge_done,
   input  logic                          csr_we,
   input  logic [blg_pkg::MV_W-1:0]      csr_valid_floor_mv,
   output logic [blg_pkg::LED_W-1:0]     rsp_led_pattern,
   output logic [blg_pkg::BAND_W-1:0]    rsp_level_index,
   output logic [blg_pkg::MV_W-1:0]      rsp_shown_mv
);
   import blg_pkg::*;

   localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 2);
   localparam int SUM_W = MV_W + CNT_W;
   localparam int DCNT_W = $clog2(SUM_W);

   mode_type          mode_ff, mode_in;
   logic [MV_W-1:0]   mv_ff, mv_in;
   logic              done_ff, done_in;
   logic [MV_W-1:0]   floor_ff, floor_in;
   logic [MV_W-1:0]   win_ff [WINDOW_DEPTH];
   logic [MV_W-1:0]   win_in [WINDOW_DEPTH];
   logic              phase_ff, phase_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [LED_W-1:0]  pat_ff, pat_in;
   logic [BAND_W-1:0] band_ff, band_in;
   logic [MV_W-1:0]   shown_ff, shown_in;

   logic [MV_W-1:0]   code_mv;
   logic [MV_W-1:0]   entry;
   logic [CNT_W:0]    trial;
   logic              qbit;
   logic [MV_W-1:0]   avg;
   logic [BAND_W-1:0] band_avg;
   logic              take_new;

   // The code times 20 is the code times 16 plus the code times 4.
   assign code_mv = (MV_W'(req_battery_code) << 4) + (MV_W'(req_battery_code) << 2) + MV_OFFSET;
   assign entry = win_ff[idx_ff];
   assign trial = {rem_ff, dvd_ff[SUM_W-1]};
   assign qbit = (trial >= {1'b0, cnt_ff});
   assign avg = (cnt_ff == '0) ? '0 : dvd_ff[MV_W-1:0];
   assign band_avg = band_of(avg, mode_ff == MODE_DISCHARGE);
   assign take_new = (mv_ff > floor_ff) && (mv_ff != win_ff[WINDOW_DEPTH-1]);

   assign sts.mode = mode_ff;
   assign sts.scan_last = (idx_ff == IDX_W'(WINDOW_DEPTH - 1));
   assign sts.div_last = (dcnt_ff == DCNT_W'(SUM_W - 1));

   always_comb begin
      mode_in = mode_ff;
      mv_in = mv_ff;
      done_in = done_ff;
      floor_in = floor_ff;
      win_in = win_ff;
      phase_in = phase_ff;
      idx_in = idx_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dcnt_in = dcnt_ff;
      pat_in = pat_ff;
      band_in = band_ff;
      shown_in = shown_ff;

      if (csr_we) begin
         floor_in = csr_valid_floor_mv;
      end

      if (cmd.capture) begin
         mode_in = mode_type'(req_display_mode);
         mv_in = code_mv;
         done_in = req_charge_done;
         idx_in = '0;
         sum_in = '0;
         cnt_in = '0;
      end

      if (cmd.clear_win) begin
         for (int k = 0; k < WINDOW_DEPTH; k++) begin
            win_in[k] = '0;
         end
      end

      if (cmd.scan_step) begin
         idx_in = idx_ff + IDX_W'(1);
         if (entry > floor_ff) begin
            sum_in = sum_ff + SUM_W'(entry);
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end

      if (cmd.insert && take_new) begin
         sum_in = sum_ff + SUM_W'(mv_ff);
         cnt_in = cnt_ff + CNT_W'(1);
         for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
            win_in[k] = win_ff[k+1];
         end
         win_in[WINDOW_DEPTH-1] = mv_ff;
      end

      if (cmd.div_load) begin
         dvd_in = sum_ff;
         rem_in = '0;
         dcnt_in = '0;
      end

      // Restoring division, one quotient bit a cycle; the quotient shifts into the dividend.
      if (cmd.div_step) begin
         dvd_in = {dvd_ff[SUM_W-2:0], qbit};
         rem_in = qbit ? CNT_W'(trial - {1'b0, cnt_ff}) : trial[CNT_W-1:0];
         dcnt_in = dcnt_ff + DCNT_W'(1);
      end

      if (cmd.result_load) begin
         unique case (mode_ff)
            MODE_OFF: begin
               pat_in = '0;
               band_in = '0;
               shown_in = '0;
            end
            MODE_SHOW: begin
               band_in = band_of(mv_ff, 1'b0);
               pat_in = pattern_of(band_in, 1'b0);
               shown_in = mv_ff;
            end
            default: begin
               shown_in = avg;
               if (done_ff) begin
                  band_in = BAND_FULL;
                  pat_in = LED_ALL;
               end else begin
                  band_in = band_avg;
                  if (band_avg != BAND_FULL) begin
                     phase_in = ~phase_ff;
                  end
                  pat_in = pattern_of(band_avg, ~phase_ff);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= FLOOR_RESET;
         phase_ff <= 1'b0;
         for (int k = 0; k < WINDOW_DEPTH; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         floor_ff <= floor_in;
         phase_ff <= phase_in;
         win_ff <= win_in;
      end
      mode_ff <= mode_in;
      mv_ff <= mv_in;
      done_ff <= done_in;
      idx_ff <= idx_in;
      sum_ff <= sum_in;
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dcnt_ff <= dcnt_in;
      pat_ff <= pat_in;
      band_ff <= band_in;
      shown_ff <= shown_in;
   end

   assign rsp_led_pattern = pat_ff;
   assign rsp_level_index = band_ff;
   assign rsp_shown_mv = shown_ff;

endmodule

### hw/rtl/blg_ctrl.sv
// Controller state machine that sequences the gauge datapath and owns both handshakes.
`timescale 1ns / 1ps

module blg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  blg_pkg::blg_sts_type sts,
   output blg_pkg::blg_cmd_type cmd
);
   import blg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_INSERT,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.mode == MODE_OFF || sts.mode == MODE_SHOW) begin
               cmd.clear_win = 1'b1;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.result_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/battery_level_led_gauge.sv
// Top level of the four-LED battery level gauge.
`timescale 1ns / 1ps

// One request beat per display tick carries the mode, the charger voltage code and the
// charge-done flag; each request yields exactly one response beat with the LED pattern,
// the level band and the judged millivolt value.
// A beat moves on either channel at a clock edge where valid is high and stall is low.
// Requests are taken one at a time: req_stall is high from acceptance until the result
// enters the output register. Off and show modes go from dispatch straight to the finish
// step. In charging and discharging modes the window is scanned one entry a cycle and the
// average comes from a restoring divider that yields one quotient bit a cycle, SUM_W bits
// in all, where SUM_W = 13 + clog2(WINDOW_DEPTH + 2). The response register holds its
// beat while rsp_stall is high, and the next request may already be accepted and worked
// on; it then waits in its last step for the register. The floor register is written
// through csr_we and csr_valid_floor_mv; the user must write it only while idle, and the
// block itself does not enforce this. Synchronous reset empties the window, clears the
// flash phase, sets the floor to 3000 mV and drops rsp_valid.

module battery_level_led_gauge #(
   parameter int WINDOW_DEPTH = blg_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_display_mode,
   input  logic [blg_pkg::CODE_W-1:0]    req_battery_code,
   input  logic                          req_charge_done,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [blg_pkg::LED_W-1:0]     rsp_led_pattern,
   output logic [blg_pkg::BAND_W-1:0]    rsp_level_index,
   output logic [blg_pkg::MV_W-1:0]      rsp_shown_mv,
   input  logic                          csr_we,
   input  logic [blg_pkg::MV_W-1:0]      csr_valid_floor_mv
);
   import blg_pkg::*;

   blg_cmd_type cmd;
   blg_sts_type sts;

   blg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   blg_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_display_mode   (req_display_mode),
      .req_battery_code   (req_battery_code),
      .req_charge_done    (req_charge_done),
      .csr_we             (csr_we),
      .csr_valid_floor_mv (csr_valid_floor_mv),
      .rsp_led_pattern    (rsp_led_pattern),
      .rsp_level_index    (rsp_level_index),
      .rsp_shown_mv       (rsp_shown_mv)
   );

endmodule
